/* design/mi3_pkg.sv */
package mi3_pkg;

	// default fraction width of the Q format
	localparam int MI_FRAC_BITS = 16;
	// one lane per cofactor
	localparam int MI_LANES = 9;
	// quotient bits produced by the divider
	localparam int MI_QBITS = 32;
	// determinant width: three 96-bit triple products summed
	localparam int MI_DW = 98;

	typedef logic signed [31:0] elem_t;
	typedef logic signed [63:0] prod_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [31:0] r00;
		logic signed [31:0] r01;
		logic signed [31:0] r02;
		logic signed [31:0] r10;
		logic signed [31:0] r11;
		logic signed [31:0] r12;
		logic signed [31:0] r20;
		logic signed [31:0] r21;
		logic signed [31:0] r22;
		logic               singular;
		logic               overflow;
	} inv_t;

	// cofactor k = m[A]*m[B] - m[C]*m[D], row-major element indexes
	localparam int CF_A [MI_LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int CF_B [MI_LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int CF_C [MI_LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int CF_D [MI_LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

/* design/stream_if.sv */
interface stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/matrix3x3_inverse.sv */
// 3x3 matrix inverse by the adjugate, signed fixed point with FRAC_BITS fraction bits.
// Channel mat carries one matrix word (m00..m22, row-major); channel inv returns one
// word per matrix: r00..r22 rounded to nearest (ties away from zero), a singular flag
// (determinant exactly zero, elements then zero) and an overflow flag (some element
// saturated to the 32-bit range).
// From accept to result valid a word passes cofactor products, determinant, magnitude and
// divider setup, 32 restoring divider steps (one quotient bit per stage, nine lanes
// side by side) and one saturation stage; the divider stage chain sets the latency.
// Throughput is one matrix per cycle unless inv.ready stalls a full pipeline.
// Every stage has its own valid bit and advances when its slot is empty or the next
// stage advances, so a stalled receiver fills the empty stages first; mat.ready drops
// only once all 41 stages hold a word, and nothing is lost or repeated.
// Reset clears the valid bits only; the data registers are not reset.
module matrix3x3_inverse
	import mi3_pkg::*;
#(
	parameter int FRAC_BITS = MI_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	stream_if.sink        mat,
	stream_if.source      inv
);

	localparam int NL = MI_LANES;
	localparam int QB = MI_QBITS;
	localparam int DW = MI_DW;
	localparam int RW = 2 * FRAC_BITS + 131;
	localparam int SH = 2 * FRAC_BITS + 1;
	localparam int D0 = 8;
	localparam int NS = D0 + QB + 1;

	// stage valid bits and advance enables
	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	assign en[NS+1] = inv.ready;
	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= mat.valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign mat.ready = en[1];
	assign inv.valid = vld_q[NS];

	// unpack the input word
	elem_t m_in [9];
	assign m_in[0] = mat.data.m00;
	assign m_in[1] = mat.data.m01;
	assign m_in[2] = mat.data.m02;
	assign m_in[3] = mat.data.m10;
	assign m_in[4] = mat.data.m11;
	assign m_in[5] = mat.data.m12;
	assign m_in[6] = mat.data.m20;
	assign m_in[7] = mat.data.m21;
	assign m_in[8] = mat.data.m22;

	// stage 1: the eighteen cofactor products
	prod_t pa_s1 [NL];
	prod_t pb_s1 [NL];
	elem_t m_s1  [3];
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < NL; k++) begin
				pa_s1[k] <= m_in[CF_A[k]] * m_in[CF_B[k]];
				pb_s1[k] <= m_in[CF_C[k]] * m_in[CF_D[k]];
			end
			for (int i = 0; i < 3; i++) begin
				m_s1[i] <= m_in[i];
			end
		end
	end

	// stage 2: cofactors, always within 64 signed bits
	prod_t cof_s2 [NL];
	elem_t m_s2   [3];
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < NL; k++) begin
				cof_s2[k] <= pa_s1[k] - pb_s1[k];
			end
			m_s2 <= m_s1;
		end
	end

	// stage 3: row 0 times first column of cofactors, in two 32-bit halves
	logic signed [64:0] pl_s3 [3];
	prod_t              ph_s3 [3];
	prod_t              cof_s3 [NL];
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				pl_s3[i] <= m_s2[i] * $signed({1'b0, cof_s2[3*i][31:0]});
				ph_s3[i] <= m_s2[i] * $signed(cof_s2[3*i][63:32]);
			end
			cof_s3 <= cof_s2;
		end
	end

	// stage 4: join the halves into the triple products
	logic signed [DW-1:0] term_s4 [3];
	prod_t                cof_s4  [NL];
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				term_s4[i] <= (DW'(ph_s3[i]) <<< 32) + DW'(pl_s3[i]);
			end
			cof_s4 <= cof_s3;
		end
	end

	// stage 5: determinant
	logic signed [DW-1:0] det_s5;
	prod_t                cof_s5 [NL];
	always_ff @(posedge clk) begin
		if (en[5]) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
		end
	end

	// stage 6: magnitudes and signs
	logic [DW-1:0] dmag_s6;
	logic          dneg_s6;
	logic          sing_s6;
	logic [63:0]   cmag_s6 [NL];
	logic [NL-1:0] cneg_s6;
	always_ff @(posedge clk) begin
		if (en[6]) begin
			dneg_s6 <= det_s5[DW-1];
			dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			sing_s6 <= (det_s5 == '0);
			for (int k = 0; k < NL; k++) begin
				cneg_s6[k] <= cof_s5[k][63];
				cmag_s6[k] <= cof_s5[k][63] ? 64'(-cof_s5[k]) : 64'(cof_s5[k]);
			end
		end
	end

	// stage 7: rounding dividend 2N + |D| and divisor 2|D|
	logic [RW-1:0] num_s7 [NL];
	logic [RW-1:0] d2_s7;
	logic          dneg_s7;
	logic          sing_s7;
	logic [NL-1:0] cneg_s7;
	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int k = 0; k < NL; k++) begin
				num_s7[k] <= (RW'(cmag_s6[k]) << SH) + RW'(dmag_s6);
			end
			d2_s7   <= RW'(dmag_s6) << 1;
			dneg_s7 <= dneg_s6;
			sing_s7 <= sing_s6;
			cneg_s7 <= cneg_s6;
		end
	end

	// divider registers; index 0 is stage 8, index j is stage 8 + j
	logic [RW-1:0] rem_sd  [QB+1][NL];
	logic [QB-1:0] quo_sd  [QB+1][NL];
	logic [NL-1:0] ovf_sd  [QB+1];
	logic [NL-1:0] cneg_sd [QB+1];
	logic [RW-1:0] d2_sd   [QB+1];
	logic          dneg_sd [QB+1];
	logic          sing_sd [QB+1];

	// stage 8: flag quotients of 2^32 or more, load the remainders
	always_ff @(posedge clk) begin
		if (en[D0]) begin
			for (int k = 0; k < NL; k++) begin
				ovf_sd[0][k] <= (num_s7[k] >= (d2_s7 << QB));
				rem_sd[0][k] <= num_s7[k];
				quo_sd[0][k] <= '0;
			end
			cneg_sd[0] <= cneg_s7;
			d2_sd[0]   <= d2_s7;
			dneg_sd[0] <= dneg_s7;
			sing_sd[0] <= sing_s7;
		end
	end

	// restoring steps, one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QB; j++) begin : g_div
		localparam int B = QB - j;
		logic [RW-1:0] sub;
		assign sub = d2_sd[j-1] << B;

		always_ff @(posedge clk) begin
			if (en[D0+j]) begin
				for (int k = 0; k < NL; k++) begin
					if (rem_sd[j-1][k] >= sub) begin
						rem_sd[j][k] <= rem_sd[j-1][k] - sub;
						quo_sd[j][k] <= quo_sd[j-1][k] | (QB'(1) << B);
					end else begin
						rem_sd[j][k] <= rem_sd[j-1][k];
						quo_sd[j][k] <= quo_sd[j-1][k];
					end
				end
				ovf_sd[j]  <= ovf_sd[j-1];
				cneg_sd[j] <= cneg_sd[j-1];
				d2_sd[j]   <= d2_sd[j-1];
				dneg_sd[j] <= dneg_sd[j-1];
				sing_sd[j] <= sing_sd[j-1];
			end
		end
	end

	// sign, saturate, force zero on a singular matrix
	elem_t         res [NL];
	logic [NL-1:0] sat;
	always_comb begin
		logic        neg;
		logic [31:0] lim;
		logic [31:0] mag;
		for (int k = 0; k < NL; k++) begin
			neg = (cneg_sd[QB][k] != dneg_sd[QB]) && (quo_sd[QB][k] != '0);
			lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			sat[k] = ovf_sd[QB][k] || (quo_sd[QB][k] > lim);
			mag = sat[k] ? lim : quo_sd[QB][k];
			res[k] = sing_sd[QB] ? '0 : (neg ? -$signed(mag) : $signed(mag));
		end
	end

	inv_t out_s41;
	always_ff @(posedge clk) begin
		if (en[NS]) begin
			out_s41.r00      <= res[0];
			out_s41.r01      <= res[1];
			out_s41.r02      <= res[2];
			out_s41.r10      <= res[3];
			out_s41.r11      <= res[4];
			out_s41.r12      <= res[5];
			out_s41.r20      <= res[6];
			out_s41.r21      <= res[7];
			out_s41.r22      <= res[8];
			out_s41.singular <= sing_sd[QB];
			out_s41.overflow <= !sing_sd[QB] && (sat != '0);
		end
	end

	assign inv.data = out_s41;

	// input stalls only when every stage holds a word
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!mat.ready |-> (vld_q == '1))
		else $error("input stalled with an empty stage");

	// a singular result carries no overflow and zero elements r00 and r22
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.data.singular |->
			!inv.data.overflow && inv.data.r00 == '0 && inv.data.r22 == '0)
		else $error("singular result with nonzero content");

	// without overflow the divider leaves a lane 0 remainder below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[D0+QB] && !ovf_sd[QB][0] |-> rem_sd[QB][0] < d2_sd[QB])
		else $error("divider remainder out of range");

	// a held output word stays unchanged while stages behind it advance
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && !inv.ready |=> $stable(out_s41))
		else $error("output word changed under stall");

endmodule
